[hw/rtl/ags_pkg.sv]
`default_nettype none

package ags_pkg;

  // Sample format codes. Code three is unused and yields a zero sample.
  typedef enum logic [1:0] {
    FMT_S16   = 2'd0,
    FMT_S8    = 2'd1,
    FMT_MULAW = 2'd2
  } fmt_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SAMPLE_FORMAT = 2'd0,
    REG_STEREO_MODE   = 2'd1,
    REG_LEFT_GAIN     = 2'd2,
    REG_RIGHT_GAIN    = 2'd3
  } reg_idx_t;

  localparam logic signed [15:0] GAIN_RESET     = 16'sd32767;
  localparam int                 SHIFT_WIDE     = 15;
  localparam int                 SHIFT_NARROW   = 7;
  localparam int                 GAIN_NARROW_SH = 8;
  localparam logic [7:0]         MULAW_OVER     = 8'd128;
  localparam logic [7:0]         MULAW_UNDER    = 8'd0;
  localparam logic [15:0]        MULAW_BIAS     = 16'd132;
  localparam logic [15:0]        MULAW_CLIP     = 16'd32635;

  // One sample after the input register: linear sample and the gain to apply.
  typedef struct packed {
    logic [1:0]         fmt;
    logic signed [15:0] sample;
    logic signed [15:0] gain;
    logic               last;
  } ags_item_t;

  function automatic logic signed [15:0] mulaw_decode(input logic [7:0] code);
    logic [7:0]  u;
    logic [15:0] t;
    u = ~code;
    t = (16'({u[3:0], 3'b000}) + MULAW_BIAS) << u[6:4];
    return u[7] ? $signed(MULAW_BIAS - t) : $signed(t - MULAW_BIAS);
  endfunction

  function automatic logic [7:0] mulaw_encode(input logic signed [15:0] x);
    logic        sign;
    logic [15:0] mag;
    logic [2:0]  expo;
    logic [3:0]  mant;
    sign = x[15];
    mag  = sign ? 16'(-x) : 16'(x);
    if (mag > MULAW_CLIP) begin
      mag = MULAW_CLIP;
    end
    mag  = mag + MULAW_BIAS;
    expo = 3'd0;
    // Exponent is the position of the leading one among bits 14 down to 8.
    for (int i = 1; i < 8; i++) begin
      if (mag[7 + i]) begin
        expo = 3'(i);
      end
    end
    mant = 4'(mag >> (4'(expo) + 4'd3));
    return ~{sign, expo, mant};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/audio_gain_scaler.sv]
`default_nettype none

// Audio gain scaler: applies a signed 1.15 gain to one sample per beat in
// signed 16-bit, signed 8-bit or mu-law format, saturating the result and
// flagging each clipped sample on tuser, with a per-buffer clip count in the
// upper half of the output tdata. It takes one beat per cycle while the
// output is not stalled; a result passes through the input register
// (gain selection, mu-law decode) and then the multiply, saturate and
// encode stage that loads the output register. Mono mode uses the average of
// the two gains; stereo mode alternates left and right starting with left.
// A beat with tlast ends a buffer and clears the clip count and channel
// toggle. Write configuration only while no beats are in flight.

module audio_gain_scaler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] sample_in
  input  wire logic        s_axis_tlast,  // last_in_buffer
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [15:0] sample_out, [31:16] clip_total
  output logic             m_axis_tuser   // clipped
);
  import ags_pkg::*;

  logic [1:0]         sample_format;
  logic               stereo_mode;
  logic signed [15:0] left_gain;
  logic signed [15:0] right_gain;
  logic               item_valid;
  logic               item_ready;
  ags_item_t          item;
  logic [15:0]        sample_out;
  logic [15:0]        clip_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_S16;
      stereo_mode   <= 1'b0;
      left_gain     <= GAIN_RESET;
      right_gain    <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SAMPLE_FORMAT: sample_format <= cfg_data[1:0];
        REG_STEREO_MODE:   stereo_mode   <= cfg_data[0];
        REG_LEFT_GAIN:     left_gain     <= $signed(cfg_data);
        REG_RIGHT_GAIN:    right_gain    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  ags_input_stage u_input (
    .clk           (clk),
    .rst           (rst),
    .sample_format (sample_format),
    .stereo_mode   (stereo_mode),
    .left_gain     (left_gain),
    .right_gain    (right_gain),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_sample     (s_axis_tdata),
    .in_last       (s_axis_tlast),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  ags_scale_stage u_scale (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .sample_out (sample_out),
    .clipped    (m_axis_tuser),
    .clip_total (clip_total)
  );

  assign m_axis_tdata = {clip_total, sample_out};

endmodule

`default_nettype wire

[hw/rtl/ags_input_stage.sv]
`default_nettype none

module ags_input_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         sample_format,
  input  wire logic               stereo_mode,
  input  wire logic signed [15:0] left_gain,
  input  wire logic signed [15:0] right_gain,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_sample,
  input  wire logic               in_last,
  output logic                    item_valid,
  input  wire logic               item_ready,
  output ags_pkg::ags_item_t      item
);
  import ags_pkg::*;

  logic               right_channel_next;
  logic               right_channel_next_next;
  logic               narrow;
  logic signed [15:0] lg;
  logic signed [15:0] rg;
  logic signed [16:0] gain_sum;
  logic signed [16:0] gain_sum_adj;
  logic signed [15:0] gain_sel;
  logic signed [15:0] sample_lin;
  logic               accept;
  ags_item_t          item_next;

  assign in_ready = !item_valid || item_ready;
  assign accept   = in_valid && in_ready;
  assign narrow   = (sample_format != FMT_S16);

  always_comb begin
    lg = narrow ? (left_gain >>> GAIN_NARROW_SH) : left_gain;
    rg = narrow ? (right_gain >>> GAIN_NARROW_SH) : right_gain;
    gain_sum = 17'(lg) + 17'(rg);
    // Halving rounds toward zero: odd negative sums get one added first.
    gain_sum_adj = gain_sum + $signed({16'b0, gain_sum[16] & gain_sum[0]});
    if (stereo_mode) begin
      gain_sel = right_channel_next ? rg : lg;
    end else begin
      gain_sel = gain_sum_adj[16:1];
    end

    case (sample_format)
      FMT_S16:   sample_lin = $signed(in_sample);
      FMT_S8:    sample_lin = $signed({{8{in_sample[7]}}, in_sample[7:0]});
      FMT_MULAW: sample_lin = mulaw_decode(in_sample[7:0]);
      default:   sample_lin = '0;
    endcase

    item_next.fmt    = sample_format;
    item_next.sample = sample_lin;
    item_next.gain   = gain_sel;
    item_next.last   = in_last;

    right_channel_next_next = right_channel_next;
    if (stereo_mode) begin
      right_channel_next_next = !right_channel_next;
    end
    if (in_last) begin
      right_channel_next_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid         <= 1'b0;
      right_channel_next <= 1'b0;
    end else begin
      if (accept) begin
        item_valid         <= 1'b1;
        right_channel_next <= right_channel_next_next;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ags_scale_stage.sv]
`default_nettype none

module ags_scale_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire ags_pkg::ags_item_t item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             sample_out,
  output logic                    clipped,
  output logic [15:0]             clip_total
);
  import ags_pkg::*;

  logic               advance;
  logic signed [31:0] product;
  logic signed [31:0] scaled;
  logic [15:0]        sample_out_next;
  logic               clip_next;
  logic [15:0]        clip_counter;
  logic [15:0]        count_next;

  assign item_ready = !out_valid || out_ready;
  assign advance    = item_valid && item_ready;

  always_comb begin
    product         = item.sample * item.gain;
    scaled          = (item.fmt == FMT_S16) ? (product >>> SHIFT_WIDE)
                                            : (product >>> SHIFT_NARROW);
    sample_out_next = '0;
    clip_next       = 1'b0;
    case (item.fmt)
      FMT_S16: begin
        if (scaled > 32'sd32767) begin
          sample_out_next = 16'h7fff;
          clip_next       = 1'b1;
        end else if (scaled < -32'sd32768) begin
          sample_out_next = 16'h8000;
          clip_next       = 1'b1;
        end else begin
          sample_out_next = scaled[15:0];
        end
      end
      FMT_S8: begin
        if (scaled > 32'sd127) begin
          sample_out_next = 16'h007f;
          clip_next       = 1'b1;
        end else if (scaled < -32'sd128) begin
          sample_out_next = 16'h0080;
          clip_next       = 1'b1;
        end else begin
          sample_out_next = {8'b0, scaled[7:0]};
        end
      end
      FMT_MULAW: begin
        if (scaled > 32'sd32767) begin
          sample_out_next = {8'b0, MULAW_OVER};
          clip_next       = 1'b1;
        end else if (scaled < -32'sd32768) begin
          sample_out_next = {8'b0, MULAW_UNDER};
          clip_next       = 1'b1;
        end else begin
          sample_out_next = {8'b0, mulaw_encode(scaled[15:0])};
        end
      end
      default: begin
        sample_out_next = '0;
        clip_next       = 1'b0;
      end
    endcase

    count_next = clip_counter;
    if (clip_next && (clip_counter != 16'hffff)) begin
      count_next = clip_counter + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      clip_counter <= '0;
    end else begin
      if (advance) begin
        out_valid    <= 1'b1;
        clip_counter <= item.last ? 16'd0 : count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= sample_out_next;
      clipped    <= clip_next;
      clip_total <= count_next;
    end
  end

endmodule

`default_nettype wire

[tb/tb_audio_gain_scaler.sv]
`timescale 1ns / 100ps

module tb_audio_gain_scaler;
  import ags_pkg::*;

  localparam logic [1:0]  FMT_UNUSED     = 2'd3;
  localparam logic [15:0] GAIN_MAX       = 16'h7FFF;
  localparam logic [15:0] GAIN_MIN       = 16'h8000;
  localparam int          MU_BIAS        = 132;
  localparam int          MU_PEAK        = 32635;
  localparam int          NUM_ROWS       = 24;
  localparam int          NUM_PHASES     = 12;
  localparam int          BEATS_PER_PHASE = 70;
  // Clipping beats in one buffer, so the clip count climbs over a long run.
  localparam int          LONG_BUFFER    = 64;
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [15:0] clip_total;
    logic        clipped;
    logic [15:0] sample_out;
  } gain_result_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic        stereo;
    logic [15:0] lgain;
    logic [15:0] rgain;
    logic [15:0] smp;
    logic        last;
    logic        typed;
    logic [15:0] want_out;
    logic        want_clip;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;  // [15:0] sample_in
  logic        s_axis_tlast;  // last_in_buffer
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // [15:0] sample_out, [31:16] clip_total
  logic        m_axis_tuser;  // clipped

  // Shadow copy of the block's registers and state.
  logic [1:0]         fmt_setting    = FMT_S16;
  logic               stereo_setting = 1'b0;
  logic signed [15:0] left_setting   = GAIN_RESET;
  logic signed [15:0] right_setting  = GAIN_RESET;
  logic               right_next     = 1'b0;
  logic [15:0]        clip_run       = 16'd0;

  gain_result_t pending_results[$];
  int           err_count      = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles   = 0;

  dir_row_t directed_rows [0:NUM_ROWS-1] = '{
    // Reset settings: full-scale gain just below one.
    '{FMT_S16,   1'b0, GAIN_MAX, GAIN_MAX, 16'h7FFF, 1'b0, 1'b1, 16'h7FFE, 1'b0},
    '{FMT_S16,   1'b0, GAIN_MAX, GAIN_MAX, 16'h8000, 1'b0, 1'b1, 16'h8001, 1'b0},
    '{FMT_S16,   1'b0, GAIN_MIN, GAIN_MIN, 16'h8000, 1'b0, 1'b1, 16'h7FFF, 1'b1},
    '{FMT_S16,   1'b0, GAIN_MIN, GAIN_MIN, 16'h7FFF, 1'b0, 1'b1, 16'h8001, 1'b0},
    '{FMT_S16,   1'b0, GAIN_MIN, GAIN_MIN, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 1'b1},
    // The averaged gain of -1/2 truncates to zero, not to -1.
    '{FMT_S16,   1'b0, GAIN_MAX, GAIN_MIN, 16'h7FFF, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{FMT_S16,   1'b0, GAIN_MIN, GAIN_MAX, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0},
    // Stereo starts on the left and must clip on the 16-bit path too.
    '{FMT_S16,   1'b1, GAIN_MIN, GAIN_MAX, 16'h8000, 1'b0, 1'b1, 16'h7FFF, 1'b1},
    '{FMT_S16,   1'b1, GAIN_MIN, GAIN_MAX, 16'h8000, 1'b1, 1'b1, 16'h8001, 1'b0},
    '{FMT_S16,   1'b1, GAIN_MIN, GAIN_MAX, 16'h8000, 1'b0, 1'b1, 16'h7FFF, 1'b1},
    // Format change keeps the toggle, so this beat is on the right.
    '{FMT_S8,    1'b1, GAIN_MIN, GAIN_MAX, 16'hFF80, 1'b0, 1'b1, 16'h0081, 1'b0},
    '{FMT_S8,    1'b1, GAIN_MIN, GAIN_MAX, 16'h0080, 1'b1, 1'b1, 16'h007F, 1'b1},
    '{FMT_S8,    1'b0, GAIN_MAX, GAIN_MAX, 16'h007F, 1'b0, 1'b1, 16'h007E, 1'b0},
    '{FMT_S8,    1'b0, GAIN_MAX, GAIN_MAX, 16'h00FF, 1'b0, 1'b1, 16'h00FF, 1'b0},
    '{FMT_S8,    1'b0, GAIN_MIN, GAIN_MIN, 16'h0080, 1'b0, 1'b1, 16'h007F, 1'b1},
    '{FMT_S8,    1'b0, GAIN_MIN, GAIN_MIN, 16'h007F, 1'b0, 1'b1, 16'h0081, 1'b0},
    // Both mu-law zero codes re-encode to the positive zero code.
    '{FMT_MULAW, 1'b0, GAIN_MAX, GAIN_MAX, 16'h00FF, 1'b0, 1'b1, 16'h00FF, 1'b0},
    '{FMT_MULAW, 1'b0, GAIN_MAX, GAIN_MAX, 16'h007F, 1'b0, 1'b1, 16'h00FF, 1'b0},
    '{FMT_MULAW, 1'b0, GAIN_MAX, GAIN_MAX, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{FMT_MULAW, 1'b0, GAIN_MIN, GAIN_MIN, 16'h0080, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{FMT_MULAW, 1'b1, GAIN_MAX, GAIN_MIN, 16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{FMT_MULAW, 1'b1, GAIN_MAX, GAIN_MIN, 16'hFF00, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{FMT_UNUSED, 1'b0, GAIN_MAX, GAIN_MAX, 16'hFFFF, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{FMT_UNUSED, 1'b1, GAIN_MAX, GAIN_MAX, 16'h8000, 1'b1, 1'b1, 16'h0000, 1'b0}
  };

  audio_gain_scaler dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint mu_expand(input logic [7:0] code);
    logic [7:0] u;
    longint     t;
    u = ~code;
    t = (longint'(u[3:0]) << 3) + MU_BIAS;
    t = t << u[6:4];
    return u[7] ? MU_BIAS - t : t - MU_BIAS;
  endfunction

  function automatic logic [7:0] mu_compress(input longint x);
    logic       sign;
    longint     mag;
    int         ex;
    logic [3:0] man;
    sign = (x < 0);
    mag  = sign ? -x : x;
    if (mag > MU_PEAK) begin
      mag = MU_PEAK;
    end
    mag = mag + MU_BIAS;
    ex  = 7;
    while (ex > 0 && !mag[7 + ex]) begin
      ex--;
    end
    man = 4'(mag >> (ex + 3));
    return ~{sign, 3'(ex), man};
  endfunction

  // Scales one sample with the current settings and advances toggle and count.
  function automatic gain_result_t scale_sample(input logic [15:0] raw, input logic last);
    gain_result_t       r;
    logic signed [15:0] s16;
    logic signed [7:0]  s8;
    longint             lg, rg, g, lin, val;
    logic               clip;
    r    = '0;
    clip = 1'b0;
    lg   = left_setting;
    rg   = right_setting;
    if (fmt_setting != FMT_S16) begin
      lg = lg >>> GAIN_NARROW_SH;
      rg = rg >>> GAIN_NARROW_SH;
    end
    if (stereo_setting) begin
      g = right_next ? rg : lg;
    end else begin
      g = (lg + rg) / 2;
    end
    case (fmt_setting)
      FMT_S16: begin
        s16 = raw;
        lin = s16;
        val = (lin * g) >>> SHIFT_WIDE;
        if (val > 32767) begin
          val  = 32767;
          clip = 1'b1;
        end else if (val < -32768) begin
          val  = -32768;
          clip = 1'b1;
        end
        r.sample_out = 16'(val);
      end
      FMT_S8: begin
        s8  = raw[7:0];
        lin = s8;
        val = (lin * g) >>> SHIFT_NARROW;
        if (val > 127) begin
          val  = 127;
          clip = 1'b1;
        end else if (val < -128) begin
          val  = -128;
          clip = 1'b1;
        end
        r.sample_out = {8'h00, 8'(val)};
      end
      FMT_MULAW: begin
        lin = mu_expand(raw[7:0]);
        val = (lin * g) >>> SHIFT_NARROW;
        if (val > 32767) begin
          r.sample_out = {8'h00, MULAW_OVER};
          clip         = 1'b1;
        end else if (val < -32768) begin
          r.sample_out = {8'h00, MULAW_UNDER};
          clip         = 1'b1;
        end else begin
          r.sample_out = {8'h00, mu_compress(val)};
        end
      end
      default: begin
        r.sample_out = 16'h0000;
      end
    endcase
    if (clip && clip_run != 16'hFFFF) begin
      clip_run = clip_run + 16'd1;
    end
    r.clipped    = clip;
    r.clip_total = clip_run;
    if (stereo_setting) begin
      right_next = ~right_next;
    end
    if (last) begin
      clip_run   = 16'd0;
      right_next = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    gain_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[15:0], 16'h0000);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== want.sample_out) begin
          report_mismatch("sample_out", m_axis_tdata[15:0], want.sample_out);
        end
        if (m_axis_tuser !== want.clipped) begin
          report_mismatch("clipped", 16'(m_axis_tuser), 16'(want.clipped));
        end
        if (m_axis_tdata[31:16] !== want.clip_total) begin
          report_mismatch("clip_total", m_axis_tdata[31:16], want.clip_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress, giving up", $realtime);
        $display("tb_audio_gain_scaler: errors");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic [15:0] smp, input logic last, input logic typed,
                           input logic [15:0] want_out, input logic want_clip);
    gain_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    r = scale_sample(smp, last);
    if (typed) begin
      r.sample_out = want_out;
      r.clipped    = want_clip;
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  // Always waits for a falling edge first, so the valid drive settles before the queue is checked.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SAMPLE_FORMAT: fmt_setting    = val[1:0];
      REG_STEREO_MODE:   stereo_setting = val[0];
      REG_LEFT_GAIN:     left_setting   = val;
      default:           right_setting  = val;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [1:0] fmt, input logic stereo,
                            input logic [15:0] lgain, input logic [15:0] rgain);
    drain_results();
    write_reg(REG_SAMPLE_FORMAT, {14'd0, fmt});
    write_reg(REG_STEREO_MODE, {15'd0, stereo});
    write_reg(REG_LEFT_GAIN, lgain);
    write_reg(REG_RIGHT_GAIN, rgain);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0:       return GAIN_MAX;
      1:       return GAIN_MIN;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return {8'($urandom), 8'h7F};
      3:       return {8'($urandom), 8'h80};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    dir_row_t row;
    logic [1:0] fmt;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_SAMPLE_FORMAT;
    cfg_data      = 16'h0000;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'h0000;
    s_axis_tlast  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = directed_rows[i];
      if (row.fmt != fmt_setting || row.stereo != stereo_setting ||
          row.lgain != left_setting || row.rgain != right_setting) begin
        set_config(row.fmt, row.stereo, row.lgain, row.rgain);
      end
      send_beat(row.smp, row.last, row.typed, row.want_out, row.want_clip);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      fmt = ($urandom_range(7) == 0) ? FMT_UNUSED : 2'($urandom_range(2));
      set_config(fmt, 1'($urandom_range(1)), pick_gain(), pick_gain());
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        // Now and then hold off until the pipeline has emptied.
        if ($urandom_range(39) == 0) begin
          drain_results();
        end
        send_beat(pick_sample(), ($urandom_range(15) == 0), 1'b0, 16'h0000, 1'b0);
      end
    end

    // One long buffer of clipping beats keeps the clip count climbing.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(FMT_S16, 1'b0, GAIN_MIN, GAIN_MIN);
    for (int n = 0; n < LONG_BUFFER; n++) begin
      send_beat(16'h8000, (n == LONG_BUFFER - 1), 1'b0, 16'h0000, 1'b0);
    end
    send_beat(16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0);

    drain_results();
    repeat (4) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_audio_gain_scaler: clean");
    end else begin
      $display("tb_audio_gain_scaler: errors");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ags_pkg.sv
hw/rtl/ags_input_stage.sv
hw/rtl/ags_scale_stage.sv
hw/rtl/audio_gain_scaler.sv
tb/tb_audio_gain_scaler.sv
